[rtl/core/wcf_pkg.sv]
// ----------------------------------------------------------------------------
// Wall column fill package
// Payload types, opcodes and register indexes for the wall column fill block.
// ----------------------------------------------------------------------------
package wcf_pkg;

    // Opcodes of the command beat. The last one is ignored by the block.
    localparam logic [1:0] OP_NEW_FRAME = 2'd0;
    localparam logic [1:0] OP_LOAD      = 2'd1;
    localparam logic [1:0] OP_STEP      = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_PROJ_SCALE   = 3'd0;
    localparam logic [2:0] REG_VIEW_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_HORIZON      = 3'd2;
    localparam logic [2:0] REG_SKY_FLOOR_EN = 3'd3;
    localparam logic [2:0] REG_SKY_COLOR    = 3'd4;
    localparam logic [2:0] REG_FLOOR_COLOR  = 3'd5;

    localparam int ADDR_W = 5;

    // Largest usable view height and the depth of 1.0 in Q12.4.
    localparam logic [7:0]  MAX_VIEW_HEIGHT = 8'd128;
    localparam logic [15:0] MIN_DEPTH       = 16'd16;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  col_a;
        logic [6:0]  col_b;
        logic [15:0] depth_a;
        logic [15:0] depth_b;
        logic [15:0] wall_color;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  column;
        logic [6:0]  line_top;
        logic [7:0]  line_length;
        logic [15:0] line_color;
        logic        last;
    } draw_t;

endpackage

[rtl/core/wall_column_fill_top.sv]
// A step fills line slots in S_CALC; S_EMIT then sends one line a cycle while lines are taken.
// A step sends up to 5 lines; no new beat is taken until its last line is registered.
// A load runs the shared one-bit-a-cycle divider three times.
// A new frame sweeps the occlusion memory, one entry a cycle.
// After reset a clearing pass zeroes both memories; no beat is taken.
// Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// Wall column fill
// Draws a wall segment one screen column at a time as delta line redraws,
// with per-column occlusion, height and color stores held in memories.
// ----------------------------------------------------------------------------
module wall_column_fill_top #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int INV_FRAC_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  wcf_pkg::cmd_t             cmd,
    output logic                      draw_valid,
    input  logic                      draw_ready,
    output wcf_pkg::draw_t            draw,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [wcf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int AW = $clog2(SCREEN_WIDTH);
    localparam int IW = INV_FRAC_BITS + 1;
    localparam int SW = INV_FRAC_BITS + 2;
    localparam int NW = INV_FRAC_BITS + 5;
    localparam int CW = $clog2(NW);
    localparam int PW = 16 + IW;
    localparam logic [NW-1:0] ONE_NUM = {1'b1, {(NW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_CLEAR_ALL,
        S_CLEAR_OCC,
        S_IDLE,
        S_DIV,
        S_CALC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic signed [9:0] top;
        logic signed [9:0] len;
        logic [15:0]       color;
    } slot_t;

    typedef struct packed {
        slot_t a;
        slot_t b;
    } strip_t;

    state_t state_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Configuration registers.
    logic [15:0] proj_scale_reg;
    logic [7:0]  view_height_reg;
    logic [7:0]  horizon_reg;
    logic        sky_floor_en_reg;
    logic [15:0] sky_color_reg;
    logic [15:0] floor_color_reg;

    // Segment state.
    logic [6:0]           cur_col_reg;
    logic [6:0]           end_col_reg;
    logic [IW-1:0]        accum_reg;
    logic signed [SW-1:0] step_reg;
    logic [15:0]          seg_color_reg;
    logic                 active_reg;

    // Load scratch and the shared divider.
    logic [6:0]    ld_ca_reg;
    logic [6:0]    ld_cb_reg;
    logic [15:0]   ld_db_reg;
    logic [15:0]   ld_color_reg;
    logic [IW-1:0] i1_reg;
    logic          neg_reg;
    logic [NW-1:0] div_num_reg;
    logic [15:0]   div_den_reg;
    logic [16:0]   div_rem_reg;
    logic [NW-1:0] div_quo_reg;
    logic [CW-1:0] div_cnt_reg;
    logic [1:0]    div_phase_reg;

    // Column step pipeline.
    logic [PW-1:0] prod_reg;
    logic          inr_reg;
    logic [6:0]    line_col_reg;
    logic [6:0]    slot_top_reg [5];
    logic [7:0]    slot_len_reg [5];
    logic [15:0]   slot_color_reg [5];
    logic [4:0]    slot_vld_reg;

    logic           draw_valid_reg;
    wcf_pkg::draw_t draw_reg;

    // Memories: occlusion marks, and height with color.
    logic          occ_mem [SCREEN_WIDTH];
    logic [23:0]   hc_mem [SCREEN_WIDTH];
    logic          occ_rd_reg;
    logic [23:0]   hc_rd_reg;
    logic          occ_we;
    logic          occ_wd;
    logic          hc_we;
    logic [23:0]   hc_wd;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] col_addr;
    logic          rd_en;

    logic accept;
    logic cfg_write;

    assign cmd_ready  = (state_reg == S_IDLE);
    assign accept     = cmd_valid && cmd_ready;
    assign draw_valid = draw_valid_reg;
    assign draw       = draw_reg;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign col_addr   = AW'(cur_col_reg);
    assign rd_en      = accept && (cmd.op == wcf_pkg::OP_STEP);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_scale_reg   <= 16'd2048;
            view_height_reg  <= 8'd128;
            horizon_reg      <= 8'd64;
            sky_floor_en_reg <= 1'b1;
            sky_color_reg    <= 16'd0;
            floor_color_reg  <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                wcf_pkg::REG_PROJ_SCALE:   proj_scale_reg   <= pwdata[15:0];
                wcf_pkg::REG_VIEW_HEIGHT:  view_height_reg  <= pwdata[7:0];
                wcf_pkg::REG_HORIZON:      horizon_reg      <= pwdata[7:0];
                wcf_pkg::REG_SKY_FLOOR_EN: sky_floor_en_reg <= pwdata[0];
                wcf_pkg::REG_SKY_COLOR:    sky_color_reg    <= pwdata[15:0];
                wcf_pkg::REG_FLOOR_COLOR:  floor_color_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (paddr[4:2])
            wcf_pkg::REG_PROJ_SCALE:   prdata = {16'd0, proj_scale_reg};
            wcf_pkg::REG_VIEW_HEIGHT:  prdata = {24'd0, view_height_reg};
            wcf_pkg::REG_HORIZON:      prdata = {24'd0, horizon_reg};
            wcf_pkg::REG_SKY_FLOOR_EN: prdata = {31'd0, sky_floor_en_reg};
            wcf_pkg::REG_SKY_COLOR:    prdata = {16'd0, sky_color_reg};
            wcf_pkg::REG_FLOOR_COLOR:  prdata = {16'd0, floor_color_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Background strip, split at the horizon when sky and floor are on.
    function automatic strip_t bg_strip(input logic signed [9:0] y,
                                        input logic signed [9:0] len,
                                        input logic signed [9:0] mid,
                                        input logic              en,
                                        input logic [15:0]       sky,
                                        input logic [15:0]       flr);
        strip_t s;
        s.a.top   = y;
        s.a.len   = len;
        s.a.color = 16'd0;
        s.b.top   = mid;
        s.b.len   = 10'sd0;
        s.b.color = flr;
        if (en)
        begin
            if (y + len <= mid)
            begin
                s.a.color = sky;
            end
            else if (y >= mid)
            begin
                s.a.color = flr;
            end
            else
            begin
                s.a.len   = mid - y;
                s.a.color = sky;
                s.b.len   = y + len - mid;
            end
        end
        return s;
    endfunction

    // Column step: height, clamping and the line candidates.
    logic [7:0]        vh;
    logic [16:0]       hraw;
    logic [7:0]        hcol;
    logic [7:0]        old_h;
    logic [15:0]       old_c;
    logic [7:0]        t_old;
    logic [7:0]        t_new;
    logic signed [9:0] vhs, hs, tos, tns, mids, bots;
    logic [15:0]       bg_sky;
    logic [15:0]       bg_floor;
    strip_t            up_strip;
    strip_t            low_strip;
    slot_t             cand [5];
    logic [4:0]        cand_vld;
    logic              col_live;

    always_comb
    begin
        vh    = (view_height_reg > wcf_pkg::MAX_VIEW_HEIGHT) ? wcf_pkg::MAX_VIEW_HEIGHT
                                                             : view_height_reg;
        hraw  = prod_reg[PW-1:INV_FRAC_BITS];
        hcol  = (hraw > {9'd0, vh}) ? vh : hraw[7:0];
        old_h = (hc_rd_reg[23:16] > vh) ? vh : hc_rd_reg[23:16];
        old_c = hc_rd_reg[15:0];
        t_old = (vh - old_h) >> 1;
        t_new = (vh - hcol) >> 1;
        vhs   = signed'({2'b00, vh});
        hs    = signed'({2'b00, hcol});
        tos   = signed'({2'b00, t_old});
        tns   = signed'({2'b00, t_new});
        mids  = signed'({2'b00, horizon_reg});
        bots  = tns + hs;
        bg_sky   = sky_floor_en_reg ? sky_color_reg : 16'd0;
        bg_floor = sky_floor_en_reg ? floor_color_reg : 16'd0;
        up_strip  = bg_strip(10'sd0, tns, mids, sky_floor_en_reg,
                             sky_color_reg, floor_color_reg);
        low_strip = bg_strip(bots, vhs - bots, mids, sky_floor_en_reg,
                             sky_color_reg, floor_color_reg);
        for (int k = 0; k < 5; k++)
        begin
            cand[k].top   = 10'sd0;
            cand[k].len   = 10'sd0;
            cand[k].color = 16'd0;
        end
        if (old_h != hcol)
        begin
            if (old_c == seg_color_reg)
            begin
                if (old_h > hcol)
                begin
                    // Shrink: background fills the freed rows above and below.
                    cand[0].top = tos;       cand[0].len = tns - tos; cand[0].color = bg_sky;
                    cand[1].top = vhs - tns; cand[1].len = tns - tos; cand[1].color = bg_floor;
                end
                else
                begin
                    // Grow: wall extends up and down.
                    cand[0].top   = tns;
                    cand[0].len   = tos - tns;
                    cand[0].color = seg_color_reg;
                    cand[1].top   = vhs - tos - 10'sd1;
                    cand[1].len   = tos - tns;
                    cand[1].color = seg_color_reg;
                end
            end
            else
            begin
                // Full repaint: upper background, wall, lower background.
                cand[0] = up_strip.a;
                cand[1] = up_strip.b;
                cand[2].top   = tns;
                cand[2].len   = hs;
                cand[2].color = seg_color_reg;
                cand[3] = low_strip.a;
                cand[4] = low_strip.b;
            end
        end
        else if (old_c != seg_color_reg)
        begin
            // Color only.
            cand[0].top   = tns;
            cand[0].len   = hs;
            cand[0].color = seg_color_reg;
        end
        col_live = inr_reg && !occ_rd_reg;
        for (int k = 0; k < 5; k++)
        begin
            cand_vld[k] = col_live && (cand[k].len > 10'sd0) && (cand[k].top >= 10'sd0);
        end
    end

    // Accumulator advance, clamped at zero.
    logic signed [IW+1:0] accum_sum;
    logic [IW-1:0]        accum_next;

    always_comb
    begin
        accum_sum  = signed'({2'b00, accum_reg}) + (IW+2)'(step_reg);
        accum_next = (accum_sum < 0) ? '0 : accum_sum[IW-1:0];
    end

    // Restoring divider, one quotient bit a cycle.
    logic [16:0]          div_r;
    logic                 div_ge;
    logic [16:0]          div_rem_next;
    logic [NW-1:0]        div_quo_next;
    logic signed [IW:0]   inv_diff;
    logic                 diff_neg;
    logic [IW-1:0]        diff_mag;
    logic [6:0]           span;
    logic signed [SW-1:0] step_val;

    always_comb
    begin
        div_r        = {div_rem_reg[15:0], div_num_reg[NW-1]};
        div_ge       = (div_r >= {1'b0, div_den_reg});
        div_rem_next = div_ge ? (div_r - {1'b0, div_den_reg}) : div_r;
        div_quo_next = {div_quo_reg[NW-2:0], div_ge};
        inv_diff     = signed'({1'b0, div_quo_next[IW-1:0]}) - signed'({1'b0, i1_reg});
        diff_neg     = inv_diff < 0;
        diff_mag     = diff_neg ? IW'(-inv_diff) : IW'(inv_diff);
        span         = (ld_cb_reg == ld_ca_reg) ? 7'd1 : (ld_cb_reg - ld_ca_reg);
        step_val     = neg_reg ? -signed'({1'b0, div_quo_next[IW-1:0]})
                               : signed'({1'b0, div_quo_next[IW-1:0]});
    end

    // Load ordering and depth clamp.
    logic        swap;
    logic [15:0] da_ord;
    logic [15:0] db_ord;

    always_comb
    begin
        swap   = cmd.col_a > cmd.col_b;
        da_ord = swap ? cmd.depth_b : cmd.depth_a;
        db_ord = swap ? cmd.depth_a : cmd.depth_b;
        if (da_ord < wcf_pkg::MIN_DEPTH)
        begin
            da_ord = wcf_pkg::MIN_DEPTH;
        end
        if (db_ord < wcf_pkg::MIN_DEPTH)
        begin
            db_ord = wcf_pkg::MIN_DEPTH;
        end
    end

    // Next line to send: lowest pending slot.
    logic [2:0] pick_idx;
    logic [4:0] slot_left;

    always_comb
    begin
        pick_idx = 3'd0;
        for (int k = 4; k >= 0; k--)
        begin
            if (slot_vld_reg[k])
            begin
                pick_idx = 3'(k);
            end
        end
        slot_left = slot_vld_reg & ~(5'b00001 << pick_idx);
    end

    // Memory write control.
    always_comb
    begin
        occ_we = 1'b0;
        occ_wd = 1'b0;
        hc_we  = 1'b0;
        hc_wd  = 24'd0;
        mem_wa = clr_cnt_reg;
        case (state_reg)
            S_CLEAR_ALL:
            begin
                occ_we = 1'b1;
                hc_we  = 1'b1;
            end
            S_CLEAR_OCC:
            begin
                occ_we = 1'b1;
            end
            S_CALC:
            begin
                mem_wa = col_addr;
                occ_we = col_live;
                occ_wd = 1'b1;
                hc_we  = col_live;
                hc_wd  = {hcol, seg_color_reg};
            end
            default: ;
        endcase
    end

    // Occlusion memory.
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[mem_wa] <= occ_wd;
        end
        if (rd_en)
        begin
            occ_rd_reg <= occ_mem[col_addr];
        end
    end

    // Height and color memory.
    always_ff @(posedge clk)
    begin
        if (hc_we)
        begin
            hc_mem[mem_wa] <= hc_wd;
        end
        if (rd_en)
        begin
            hc_rd_reg <= hc_mem[col_addr];
        end
    end

    // Sequencer, segment state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR_ALL;
            clr_cnt_reg    <= '0;
            cur_col_reg    <= 7'd0;
            end_col_reg    <= 7'd0;
            accum_reg      <= '0;
            step_reg       <= '0;
            seg_color_reg  <= 16'd0;
            active_reg     <= 1'b0;
            div_cnt_reg    <= '0;
            div_phase_reg  <= 2'd0;
            slot_vld_reg   <= 5'd0;
            draw_valid_reg <= 1'b0;
        end
        else
        begin
            if (draw_valid_reg && draw_ready)
            begin
                draw_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR_ALL, S_CLEAR_OCC:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(SCREEN_WIDTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd.op)
                            wcf_pkg::OP_NEW_FRAME:
                            begin
                                clr_cnt_reg <= '0;
                                state_reg   <= S_CLEAR_OCC;
                            end
                            wcf_pkg::OP_LOAD:
                            begin
                                ld_ca_reg     <= swap ? cmd.col_b : cmd.col_a;
                                ld_cb_reg     <= swap ? cmd.col_a : cmd.col_b;
                                ld_db_reg     <= db_ord;
                                ld_color_reg  <= cmd.wall_color;
                                div_num_reg   <= ONE_NUM;
                                div_den_reg   <= da_ord;
                                div_rem_reg   <= 17'd0;
                                div_quo_reg   <= '0;
                                div_cnt_reg   <= '0;
                                div_phase_reg <= 2'd0;
                                state_reg     <= S_DIV;
                            end
                            wcf_pkg::OP_STEP:
                            begin
                                if (active_reg)
                                begin
                                    prod_reg  <= PW'(proj_scale_reg) * PW'(accum_reg);
                                    inr_reg   <= (32'(cur_col_reg) < SCREEN_WIDTH);
                                    state_reg <= S_CALC;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV:
                begin
                    div_num_reg <= {div_num_reg[NW-2:0], 1'b0};
                    div_rem_reg <= div_rem_next;
                    div_quo_reg <= div_quo_next;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CW'(NW - 1))
                    begin
                        div_cnt_reg   <= '0;
                        div_rem_reg   <= 17'd0;
                        div_quo_reg   <= '0;
                        div_phase_reg <= div_phase_reg + 1'b1;
                        if (div_phase_reg == 2'd0)
                        begin
                            i1_reg      <= div_quo_next[IW-1:0];
                            div_num_reg <= ONE_NUM;
                            div_den_reg <= ld_db_reg;
                        end
                        else if (div_phase_reg == 2'd1)
                        begin
                            neg_reg     <= diff_neg;
                            div_num_reg <= NW'(diff_mag);
                            div_den_reg <= {9'd0, span};
                        end
                        else
                        begin
                            step_reg      <= step_val;
                            accum_reg     <= i1_reg;
                            cur_col_reg   <= ld_ca_reg;
                            end_col_reg   <= ld_cb_reg;
                            seg_color_reg <= ld_color_reg;
                            active_reg    <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_CALC:
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        slot_top_reg[k]   <= cand[k].top[6:0];
                        slot_len_reg[k]   <= cand[k].len[7:0];
                        slot_color_reg[k] <= cand[k].color;
                    end
                    slot_vld_reg <= cand_vld;
                    line_col_reg <= cur_col_reg;
                    accum_reg    <= accum_next;
                    if (cur_col_reg >= end_col_reg)
                    begin
                        active_reg <= 1'b0;
                    end
                    else
                    begin
                        cur_col_reg <= cur_col_reg + 7'd1;
                    end
                    state_reg <= (cand_vld != 5'd0) ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (!draw_valid_reg || draw_ready)
                    begin
                        draw_reg.column      <= line_col_reg;
                        draw_reg.line_top    <= slot_top_reg[pick_idx];
                        draw_reg.line_length <= slot_len_reg[pick_idx];
                        draw_reg.line_color  <= slot_color_reg[pick_idx];
                        draw_reg.last        <= (slot_left == 5'd0);
                        draw_valid_reg       <= 1'b1;
                        slot_vld_reg         <= slot_left;
                        if (slot_left == 5'd0)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // A line that is not the last of its column is followed at once by another.
    a_lines_follow: assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && draw_ready && !draw.last |=> draw_valid)
        else $error("line beat missing after a non-final line");

    // No zero-length line is ever shown.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid |-> (draw.line_length != 8'd0))
        else $error("zero-length line on the draw channel");

    // The step evaluation follows an accepted beat.
    a_calc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> $past(accept))
        else $error("column evaluation without a command beat");

    // While pending lines remain the block takes no command.
    a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_vld_reg != 5'd0) && (state_reg == S_EMIT) |-> !cmd_ready)
        else $error("command taken while lines are pending");
`endif

endmodule
